// ----- rtl/semiprime_range_checker_top_macros.svh -----
// Assertion macros for the checker of the semiprime range checker.
`ifndef SEMIPRIME_RANGE_CHECKER_TOP_MACROS_SVH
`define SEMIPRIME_RANGE_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/spc_pkg.sv -----
// Package with the shared types and constants of the semiprime range checker.
package spc_pkg;

  // Width of the candidate and tested value fields on the channels.
  localparam int unsigned CAND_W = 16;

  // Smallest semiprime and smallest prime.
  localparam int unsigned MIN_SEMI  = 4;
  localparam int unsigned MIN_PRIME = 2;

  // First odd trial divisor.
  localparam int unsigned FIRST_ODD_DIV = 3;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } spc_state_t;

endpackage

// ----- rtl/spc_if.sv -----
// Valid/ready channel interfaces for candidates and test results.
interface spc_in_if;
  logic                       valid;
  logic                       ready;
  logic [spc_pkg::CAND_W-1:0] candidate;
  logic                       range_end;

  modport source (output valid, output candidate, output range_end, input ready);
  modport sink   (input valid, input candidate, input range_end, output ready);
endinterface

interface spc_out_if;
  logic                       valid;
  logic                       ready;
  logic [spc_pkg::CAND_W-1:0] tested_value;
  logic                       is_semiprime;
  logic                       range_end_out;
  logic                       any_found;

  modport source (output valid, output tested_value, output is_semiprime,
                  output range_end_out, output any_found, input ready);
  modport sink   (input valid, input tested_value, input is_semiprime,
                  input range_end_out, input any_found, output ready);
endinterface

// ----- rtl/semiprime_range_checker_top.sv -----
// Semiprime range checker: tests each candidate by trial division and tracks
// whether any semiprime was seen in the current range. One candidate is in
// work at a time. The test first finds the least divisor of the candidate and
// then checks that the cofactor is prime; each odd trial divisor costs one run
// of the bit-serial divider. A result waits in the output register while the
// next candidate is taken and tested.
module semiprime_range_checker_top #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  spc_in_if.sink    in_chan,
  spc_out_if.source out_chan
);

  localparam int unsigned W    = VALUE_BITS;
  localparam int unsigned CW   = spc_pkg::CAND_W;
  localparam int unsigned EXTW = (W > CW) ? W : CW;

  spc_pkg::spc_state_t state_r, state_nxt;

  logic [W-1:0]   n_r, n_nxt;
  logic           last_r, last_nxt;
  logic [W-1:0]   t_r, t_nxt;
  logic           phase_r, phase_nxt;
  logic [W-1:0]   d_r, d_nxt;
  logic [W+1:0]   sq_r, sq_nxt;
  logic           semi_r, semi_nxt;
  logic           found_r, found_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [CW-1:0]  out_val_r, out_val_nxt;
  logic           out_semi_r, out_semi_nxt;
  logic           out_end_r, out_end_nxt;
  logic           out_any_r, out_any_nxt;

  logic [EXTW-1:0] cand_ext;
  logic [W-1:0]    cand_n;
  logic            div_start;
  logic            div_done;
  logic [W-1:0]    div_quo;
  logic [W-1:0]    div_rem;
  logic            found_upd;

  // Candidate masked to the working width.
  assign cand_ext = EXTW'(in_chan.candidate);
  assign cand_n   = cand_ext[W-1:0];

  spc_divider #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (t_r),
    .divisor   (d_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign found_upd = found_r | semi_r;

  // Sequencer: least-divisor search of the candidate, then a primality search
  // of the cofactor, both through the shared divider.
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    last_nxt      = last_r;
    t_nxt         = t_r;
    phase_nxt     = phase_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    semi_nxt      = semi_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_semi_nxt  = out_semi_r;
    out_end_nxt   = out_end_r;
    out_any_nxt   = out_any_r;
    div_start     = 1'b0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      spc_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          n_nxt     = cand_n;
          t_nxt     = cand_n;
          last_nxt  = in_chan.range_end;
          phase_nxt = 1'b0;
          state_nxt = spc_pkg::ST_START;
        end
      end

      spc_pkg::ST_START: begin
        d_nxt  = W'(spc_pkg::FIRST_ODD_DIV);
        sq_nxt = (W+2)'(spc_pkg::FIRST_ODD_DIV * spc_pkg::FIRST_ODD_DIV);
        if (!phase_r) begin
          // Candidate: small values are never semiprimes, even ones split by 2.
          if (t_r < W'(spc_pkg::MIN_SEMI)) begin
            semi_nxt  = 1'b0;
            state_nxt = spc_pkg::ST_FINISH;
          end else if (!t_r[0]) begin
            t_nxt     = t_r >> 1;
            phase_nxt = 1'b1;
          end else begin
            state_nxt = spc_pkg::ST_CHECK;
          end
        end else begin
          // Cofactor: below two is not prime, an even one is prime only as 2.
          if (t_r < W'(spc_pkg::MIN_PRIME)) begin
            semi_nxt  = 1'b0;
            state_nxt = spc_pkg::ST_FINISH;
          end else if (!t_r[0]) begin
            semi_nxt  = (t_r == W'(spc_pkg::MIN_PRIME));
            state_nxt = spc_pkg::ST_FINISH;
          end else begin
            state_nxt = spc_pkg::ST_CHECK;
          end
        end
      end

      spc_pkg::ST_CHECK: begin
        // Once the divisor squared passes the target, the target is prime.
        if (sq_r > (W+2)'(t_r)) begin
          semi_nxt  = phase_r;
          state_nxt = spc_pkg::ST_FINISH;
        end else begin
          div_start = 1'b1;
          state_nxt = spc_pkg::ST_DIV;
        end
      end

      spc_pkg::ST_DIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            if (!phase_r) begin
              t_nxt     = div_quo;
              phase_nxt = 1'b1;
              state_nxt = spc_pkg::ST_START;
            end else begin
              semi_nxt  = 1'b0;
              state_nxt = spc_pkg::ST_FINISH;
            end
          end else begin
            // Next odd divisor: (d + 2)^2 = d^2 + 4d + 4.
            d_nxt     = d_r + W'(2);
            sq_nxt    = sq_r + (W+2)'({d_r, 2'b00}) + (W+2)'(4);
            state_nxt = spc_pkg::ST_CHECK;
          end
        end
      end

      spc_pkg::ST_FINISH: begin
        // Load the output register once it is free or being emptied.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = CW'(n_r);
          out_semi_nxt  = semi_r;
          out_end_nxt   = last_r;
          out_any_nxt   = last_r & found_upd;
          found_nxt     = last_r ? 1'b0 : found_upd;
          state_nxt     = spc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = spc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spc_pkg::ST_IDLE;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    last_r     <= last_nxt;
    t_r        <= t_nxt;
    phase_r    <= phase_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    semi_r     <= semi_nxt;
    out_val_r  <= out_val_nxt;
    out_semi_r <= out_semi_nxt;
    out_end_r  <= out_end_nxt;
    out_any_r  <= out_any_nxt;
  end

  assign in_chan.ready          = (state_r == spc_pkg::ST_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.tested_value  = out_val_r;
  assign out_chan.is_semiprime  = out_semi_r;
  assign out_chan.range_end_out = out_end_r;
  assign out_chan.any_found     = out_any_r;

endmodule

// ----- rtl/spc_divider.sv -----
// Bit-serial restoring divider: one quotient bit per clock cycle.
module spc_divider #(
  parameter int unsigned W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int unsigned CW = $clog2(W + 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  div_r, div_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
      end else begin
        rem_nxt = trial[W-1:0];
      end
      quo_nxt = {quo_r[W-2:0], ~diff[W]};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/spc_checker.sv -----
// Port-level assertions for the semiprime range checker and their binding.
`include "semiprime_range_checker_top_macros.svh"

module spc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [spc_pkg::CAND_W-1:0] tested_value,
  input logic                       is_semiprime,
  input logic                       range_end_out,
  input logic                       any_found
);

  // A stalled result keeps its contents.
  `SPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(tested_value) && $stable(is_semiprime)
                   && $stable(range_end_out) && $stable(any_found),
                   "result changed while stalled")

  // Only one candidate is in work: input closes right after a transaction.
  `SPC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready,
                   "input ready right after a transaction")

  // The range flag shows only on the final result of a range.
  `SPC_ASSERT_NOW(a_any_on_end, out_valid && any_found, range_end_out,
                  "any_found set on a result that does not end a range")

  // A semiprime on the final result must raise the range flag.
  `SPC_ASSERT_NOW(a_any_covers_last, out_valid && is_semiprime && range_end_out, any_found,
                  "semiprime in range not reported")

  // No value below four is a semiprime.
  `SPC_ASSERT_NOW(a_semi_min, out_valid && is_semiprime,
                  tested_value >= spc_pkg::CAND_W'(spc_pkg::MIN_SEMI),
                  "value below four flagged as semiprime")

endmodule

bind semiprime_range_checker_top spc_checker u_spc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .tested_value  (out_chan.tested_value),
  .is_semiprime  (out_chan.is_semiprime),
  .range_end_out (out_chan.range_end_out),
  .any_found     (out_chan.any_found)
);

// ----- tb/sv/semiprime_range_checker_top_tb.sv -----
// Self-checking testbench of the semiprime range checker, with its own trial-division predictor.
module semiprime_range_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_BITS   = 16;
  localparam int unsigned RANDOM_ITEMS = 290;
  localparam int unsigned PAUSE_AT     = 120;   // sender waits for a drained block here
  localparam int unsigned HOLD_AT      = 40;    // receiver starts its long hold-off here
  localparam int unsigned HOLD_LEN     = 3000;
  localparam int unsigned STALL_LIMIT  = 40000;
  localparam int unsigned DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [spc_pkg::CAND_W-1:0] candidate;
    logic                       range_end;
  } cand_item_t;

  typedef struct packed {
    logic [spc_pkg::CAND_W-1:0] tested_value;
    logic                       is_semiprime;
    logic                       range_end_out;
    logic                       any_found;
  } verdict_t;

  logic clk;
  logic rst_n;

  spc_in_if  in_chan ();
  spc_out_if out_chan ();

  semiprime_range_checker_top #(
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  cand_item_t  pending_items[$];
  verdict_t    expected_verdicts[$];
  int unsigned total_items;
  int unsigned in_count;
  int unsigned out_count;
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned hold_left;
  bit          hold_done;
  bit          pause_done;
  bit          found_in_range;
  int unsigned semiprime_count;
  int unsigned ranges_closed;
  int unsigned ranges_with_hit;

  // Smallest divisor of n (n >= 2) that is at least two; n itself for a prime.
  function automatic int unsigned least_factor(int unsigned n);
    int unsigned d;
    if (n % spc_pkg::MIN_PRIME == 0) return spc_pkg::MIN_PRIME;
    d = spc_pkg::FIRST_ODD_DIV;
    while (d * d <= n) begin
      if (n % d == 0) return d;
      d += 2;
    end
    return n;
  endfunction

  function automatic bit prime_value(int unsigned n);
    if (n < spc_pkg::MIN_PRIME) return 1'b0;
    return least_factor(n) == n;
  endfunction

  function automatic bit semiprime_value(int unsigned n);
    int unsigned p;
    if (n < spc_pkg::MIN_SEMI) return 1'b0;
    p = least_factor(n);
    if (p == n) return 1'b0;
    return prime_value(n / p);
  endfunction

  // Works out the verdict of one accepted candidate and updates the range flag.
  function automatic void predict_verdict(cand_item_t it);
    verdict_t    v;
    int unsigned value;
    value = int'(it.candidate) & ((1 << VALUE_BITS) - 1);
    v.tested_value  = value[spc_pkg::CAND_W-1:0];
    v.is_semiprime  = semiprime_value(value);
    v.range_end_out = it.range_end;
    v.any_found     = 1'b0;
    found_in_range  = found_in_range | v.is_semiprime;
    if (v.is_semiprime) semiprime_count++;
    if (it.range_end) begin
      v.any_found    = found_in_range;
      found_in_range = 1'b0;
      ranges_closed++;
      if (v.any_found) ranges_with_hit++;
    end
    expected_verdicts.push_back(v);
  endfunction

  // Neither side idles while this window of transactions goes through.
  function automatic bit calm_window(int unsigned n);
    return n >= 200 && n < 260;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic add_item(int unsigned cand, bit last);
    cand_item_t it;
    it.candidate = cand[spc_pkg::CAND_W-1:0];
    it.range_end = last;
    pending_items.push_back(it);
  endtask

  // Candidate values: mostly small, some over the full width, some corner values.
  function automatic int unsigned pick_candidate();
    int unsigned roll;
    int unsigned corner[6];
    corner = '{0, 1, 2, 3, 4, 9};
    roll = $urandom_range(0, 99);
    if (roll < 10) return $urandom_range(0, 65535);
    if (roll < 15) return corner[$urandom_range(0, 5)];
    return $urandom_range(0, 4095);
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: offers the queued candidates and records each accepted transaction.
  always @(posedge clk) begin : drive_candidates
    int unsigned taken;
    bit          hold_back;
    if (!rst_n) begin
      in_chan.valid     <= 1'b0;
      in_chan.candidate <= '0;
      in_chan.range_end <= 1'b0;
    end else begin
      taken = in_count;
      if (in_chan.valid && in_chan.ready) begin
        predict_verdict(pending_items.pop_front());
        taken++;
      end
      in_count <= taken;
      if (!in_chan.valid || in_chan.ready) begin
        hold_back = 1'b0;
        if (taken == PAUSE_AT && !pause_done) begin
          if (out_count == taken) pause_done = 1'b1;
          else hold_back = 1'b1;
        end
        if (!calm_window(taken) && $urandom_range(0, 99) < 15) hold_back = 1'b1;
        if (pending_items.size() != 0 && !hold_back) begin
          in_chan.valid     <= 1'b1;
          in_chan.candidate <= pending_items[0].candidate;
          in_chan.range_end <= pending_items[0].range_end;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off that fills the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_left      <= 0;
      hold_done      <= 1'b0;
    end else if (hold_left != 0) begin
      out_chan.ready <= 1'b0;
      hold_left      <= hold_left - 1;
    end else if (!hold_done && out_count >= HOLD_AT) begin
      out_chan.ready <= 1'b0;
      hold_left      <= HOLD_LEN;
      hold_done      <= 1'b1;
    end else begin
      out_chan.ready <= calm_window(in_count) || $urandom_range(0, 99) >= 15;
    end
  end

  // Monitor: compares each result transaction with the oldest expected verdict.
  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (!rst_n) begin
      out_count <= 0;
    end else if (out_chan.valid && out_chan.ready) begin
      out_count <= out_count + 1;
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result for value %0d", out_chan.tested_value));
      end else begin
        want = expected_verdicts.pop_front();
        if (out_chan.tested_value !== want.tested_value)
          report_mismatch($sformatf("tested_value got %0d want %0d",
                                    out_chan.tested_value, want.tested_value));
        if (out_chan.is_semiprime !== want.is_semiprime)
          report_mismatch($sformatf("is_semiprime of %0d got %b want %b",
                                    want.tested_value, out_chan.is_semiprime,
                                    want.is_semiprime));
        if (out_chan.range_end_out !== want.range_end_out)
          report_mismatch($sformatf("range_end_out of %0d got %b want %b",
                                    want.tested_value, out_chan.range_end_out,
                                    want.range_end_out));
        if (out_chan.any_found !== want.any_found)
          report_mismatch($sformatf("any_found of %0d got %b want %b",
                                    want.tested_value, out_chan.any_found, want.any_found));
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d of %0d candidates in, %0d results out",
               idle_cycles, in_count, total_items, out_count);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin : run_test
    int unsigned len;
    int unsigned k;
    int unsigned random_count;
    in_chan.valid     = 1'b0;
    in_chan.candidate = '0;
    in_chan.range_end = 1'b0;
    out_chan.ready    = 1'b0;
    rst_n             = 1'b0;
    in_count          = 0;
    error_count       = 0;
    pause_done        = 1'b0;
    found_in_range    = 1'b0;
    semiprime_count   = 0;
    ranges_closed     = 0;
    ranges_with_hit   = 0;

    // Zero, one and small primes: a range with nothing found.
    add_item(0, 1'b0);
    add_item(1, 1'b0);
    add_item(2, 1'b0);
    add_item(3, 1'b1);
    // Smallest semiprime, a square, alone in its range.
    add_item(4, 1'b1);
    // Nine is a semiprime; eight and twelve have three factors.
    add_item(9, 1'b0);
    add_item(8, 1'b0);
    add_item(7, 1'b0);
    add_item(12, 1'b1);
    // The hit is before the last item of the range.
    add_item(15, 1'b0);
    add_item(16, 1'b1);
    // Largest value, many factors.
    add_item(65535, 1'b1);
    // Largest prime, top bit alone, and the square of a large prime.
    add_item(65521, 1'b0);
    add_item(32768, 1'b0);
    add_item(63001, 1'b1);
    // Even value whose cofactor is a large prime.
    add_item(65498, 1'b1);
    add_item(49, 1'b0);
    add_item(64507, 1'b0);
    add_item(30, 1'b1);
    add_item(1, 1'b1);

    // Random ranges of one to eight candidates.
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      len = $urandom_range(1, 8);
      for (k = 0; k < len; k++) add_item(pick_candidate(), k == len - 1);
      random_count += len;
    end
    total_items = pending_items.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (in_count != total_items || out_count != total_items) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d candidates in %0d ranges: %0d semiprimes, %0d ranges with a hit.",
             total_items, ranges_closed, semiprime_count, ranges_with_hit);
    $display("Covered a long result hold-off, a drained-block pause and %0d mismatches.",
             error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/spc_pkg.sv
rtl/spc_if.sv
rtl/spc_divider.sv
rtl/semiprime_range_checker_top.sv
rtl/spc_checker.sv
tb/sv/semiprime_range_checker_top_tb.sv
